// File: rtl/core/afrf_pkg.sv
// afrf_pkg: shared types and constants for the audio packet ring with rate feedback
// no dependencies; imported by all rtl/core modules

package afrf_pkg;

	localparam int SlotCountDef = 8;

	localparam logic [9:0] MaxPacketBytes = 10'd1023;
	localparam int         FracBits       = 14;
	localparam int         FracTenth      = 1638;

	localparam logic [23:0] Rate192k = 24'd192000;
	localparam logic [23:0] Rate176k = 24'd176400;
	localparam logic [23:0] Rate96k  = 24'd96000;
	localparam logic [23:0] Rate88k  = 24'd88200;
	localparam logic [23:0] Rate48k  = 24'd48000;
	localparam logic [23:0] Rate44k  = 24'd44100;

	typedef enum logic [2:0] {
		CMD_RX_PACKET = 3'd0,
		CMD_FETCH     = 3'd1,
		CMD_FEEDBACK  = 3'd2,
		CMD_START     = 3'd3,
		CMD_STOP      = 3'd4
	} afrf_cmd_t;

	typedef struct packed {
		logic [2:0]  slot_index;
		logic [9:0]  packet_length;
		logic        packet_valid;
		logic [21:0] feedback_value;
		logic        overflow_flag;
		logic        playback_started;
		logic        playback_stopped;
		logic [3:0]  fill_level;
	} afrf_result_t;

endpackage

// File: rtl/core/afrf_if.sv
// afrf_if: valid/ready channel interfaces for command words and result words
// no dependencies

interface afrf_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [9:0] rx_length;

	modport source (output valid, cmd, rx_length, input ready);
	modport sink   (input valid, cmd, rx_length, output ready);
endinterface

interface afrf_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  slot_index;
	logic [9:0]  packet_length;
	logic        packet_valid;
	logic [21:0] feedback_value;
	logic        overflow_flag;
	logic        playback_started;
	logic        playback_stopped;
	logic [3:0]  fill_level;

	modport source (output valid, slot_index, packet_length, packet_valid, feedback_value,
		overflow_flag, playback_started, playback_stopped, fill_level, input ready);
	modport sink   (input valid, slot_index, packet_length, packet_valid, feedback_value,
		overflow_flag, playback_started, playback_stopped, fill_level, output ready);
endinterface

// File: rtl/core/audio_packet_fifo_rate_feedback.sv
// audio_packet_fifo_rate_feedback: top level of the packet slot ring with rate feedback
// depends on afrf_pkg, afrf_if, afrf_slot_mem and afrf_ring_ctrl
//
// usage
//  - cmd_ch carries command words (cmd, rx_length); res_ch returns one result word
//    per command word, in order
//  - cfg_we/cfg_wdata write the sample rate in hertz; write only while the block is idle
//  - a command word is accepted on an edge with cmd_ch valid and ready both high
//  - the command stage and the output register lie between acceptance and res_ch
//  - a new command word is not taken while the previous one is in the command stage;
//    the slot memory's registered read sits between acceptance and the pointer update,
//    and the next word is taken only after that update
//  - res_ch has an output register: a new word is taken while the previous result
//    is being handed off, so a receiver that takes every result at once does not
//    slow the command words
//  - when the receiver stalls, the result is held and cmd_ch ready drops until
//    the result is taken
//  - reset: ring empty, pointers zero, flags clear, sample rate zero; the slot
//    memory is not cleared, since a slot is only read after it has been written

module audio_packet_fifo_rate_feedback
	import afrf_pkg::*;
#(
	parameter int SLOT_COUNT = SlotCountDef,
	localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	afrf_in_if.sink     cmd_ch,
	afrf_out_if.source  res_ch
);

	logic            accept;
	logic            busy;
	logic            res_valid;
	afrf_result_t    res;
	afrf_result_t    res_q;
	logic            out_v_q;
	logic            mem_we, mem_re;
	logic [IdxW-1:0] mem_waddr, mem_raddr;
	logic [9:0]      mem_wdata, mem_rdata;

	// take a word only with nothing in flight and the output register free or draining
	assign cmd_ch.ready = !busy && (!out_v_q || res_ch.ready);
	assign accept       = cmd_ch.valid && cmd_ch.ready;

	afrf_ring_ctrl #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.cmd       (cmd_ch.cmd),
		.rx_length (cmd_ch.rx_length),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	afrf_slot_mem #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: loads only when empty, which the ready rule guarantees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_valid) begin
			out_v_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign res_ch.valid            = out_v_q;
	assign res_ch.slot_index       = res_q.slot_index;
	assign res_ch.packet_length    = res_q.packet_length;
	assign res_ch.packet_valid     = res_q.packet_valid;
	assign res_ch.feedback_value   = res_q.feedback_value;
	assign res_ch.overflow_flag    = res_q.overflow_flag;
	assign res_ch.playback_started = res_q.playback_started;
	assign res_ch.playback_stopped = res_q.playback_stopped;
	assign res_ch.fill_level       = res_q.fill_level;

endmodule

// File: rtl/core/afrf_slot_mem.sv
// afrf_slot_mem: packet length store, one write and one registered read port
// depends on afrf_pkg

module afrf_slot_mem
	import afrf_pkg::*;
#(
	parameter int SLOT_COUNT = SlotCountDef,
	localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [IdxW-1:0] waddr,
	input  logic [9:0]      wdata,
	input  logic            re,
	input  logic [IdxW-1:0] raddr,
	output logic [9:0]      rdata
);

	logic [9:0] mem_q [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/afrf_ring_ctrl.sv
// afrf_ring_ctrl: ring pointers, fill count, flags, rate feedback and command stage
// depends on afrf_pkg; drives the afrf_slot_mem ports

module afrf_ring_ctrl
	import afrf_pkg::*;
#(
	parameter int SLOT_COUNT = SlotCountDef,
	localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
	localparam int CntW = $clog2(SLOT_COUNT + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [23:0]     cfg_wdata,
	input  logic            accept,
	input  logic [2:0]      cmd,
	input  logic [9:0]      rx_length,
	output logic            busy,
	output logic            res_valid,
	output afrf_result_t    res,
	output logic            mem_we,
	output logic [IdxW-1:0] mem_waddr,
	output logic [9:0]      mem_wdata,
	output logic            mem_re,
	output logic [IdxW-1:0] mem_raddr,
	input  logic [9:0]      mem_rdata
);

	localparam logic [CntW-1:0] FullCnt = CntW'(SLOT_COUNT);
	localparam logic [CntW-1:0] HiMark  = CntW'(SLOT_COUNT / 2 + 1);
	localparam logic [CntW-1:0] LoMark  = CntW'(SLOT_COUNT / 2 - 1);

	logic [23:0]     rate_q;
	logic [IdxW-1:0] rd_q, wr_q, rd_d, wr_d;
	logic [CntW-1:0] held_q, held_d;
	logic            rd_rdy_q, wr_rdy_q, ovf_q, play_q;
	logic            rd_rdy_d, wr_rdy_d, ovf_d, play_d;
	logic            v_s1;
	logic [2:0]      cmd_s1;
	logic [9:0]      len_s1;
	logic [9:0]      len_sat;
	logic [IdxW-1:0] slot;
	logic [7:0]      whole;
	logic [13:0]     frac;
	logic            known;
	logic [21:0]     fb;

	function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
		return (idx == IdxW'(SLOT_COUNT - 1)) ? '0 : idx + 1'b1;
	endfunction

	// nominal rate lookup and fill-based trim
	always_comb begin
		known = 1'b1;
		whole = 8'd0;
		frac  = 14'd0;
		case (rate_q)
			Rate192k: begin whole = 8'd192; frac = 14'(0 * FracTenth); end
			Rate176k: begin whole = 8'd176; frac = 14'(4 * FracTenth); end
			Rate96k:  begin whole = 8'd96;  frac = 14'(0 * FracTenth); end
			Rate88k:  begin whole = 8'd88;  frac = 14'(2 * FracTenth); end
			Rate48k:  begin whole = 8'd48;  frac = 14'(0 * FracTenth); end
			Rate44k:  begin whole = 8'd44;  frac = 14'(1 * FracTenth); end
			default:  known = 1'b0;
		endcase
		if (held_q > HiMark) begin
			whole = whole - 8'd1;
		end else if (held_q < LoMark) begin
			whole = whole + 8'd1;
		end
		fb = known ? {whole, frac} : 22'd0;
	end

	assign len_sat = (len_s1 > MaxPacketBytes) ? MaxPacketBytes : len_s1;

	always_comb begin
		rd_d     = rd_q;
		wr_d     = wr_q;
		held_d   = held_q;
		rd_rdy_d = rd_rdy_q;
		wr_rdy_d = wr_rdy_q;
		ovf_d    = ovf_q;
		play_d   = play_q;
		mem_we   = 1'b0;
		res      = '0;
		slot     = wr_q;
		unique case (cmd_s1)
			CMD_RX_PACKET: begin
				if (len_sat != 10'd0) begin
					if (wr_rdy_q) begin
						mem_we   = v_s1;
						wr_d     = idx_inc(wr_q);
						held_d   = held_q + 1'b1;
						rd_rdy_d = 1'b1;
						wr_rdy_d = (idx_inc(wr_q) != rd_q);
					end else begin
						ovf_d = 1'b1;
					end
				end
				if (held_d != '0) begin
					res.playback_started = !play_q;
					play_d               = 1'b1;
				end
				slot = wr_d;
			end
			CMD_FETCH: begin
				slot = rd_q;
				if (rd_rdy_q) begin
					res.packet_length = mem_rdata;
					res.packet_valid  = 1'b1;
					rd_d              = idx_inc(rd_q);
					held_d            = held_q - 1'b1;
					wr_rdy_d          = 1'b1;
					rd_rdy_d          = (wr_q != idx_inc(rd_q));
				end
			end
			CMD_FEEDBACK: begin
				res.feedback_value = fb;
			end
			CMD_START, CMD_STOP: begin
				if (cmd_s1 == CMD_STOP) begin
					res.playback_stopped = play_q;
					play_d               = 1'b0;
				end
				rd_d     = '0;
				wr_d     = '0;
				held_d   = '0;
				rd_rdy_d = 1'b0;
				wr_rdy_d = 1'b1;
				ovf_d    = 1'b0;
				slot     = '0;
			end
			default: ;
		endcase
		res.slot_index    = 3'(slot);
		res.overflow_flag = ovf_d;
		res.fill_level    = 4'(held_d);
	end

	assign mem_waddr = wr_q;
	assign mem_wdata = len_sat;
	assign mem_re    = accept;
	assign mem_raddr = rd_q;
	assign busy      = v_s1;
	assign res_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
		end else if (cfg_we) begin
			rate_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			len_s1 <= rx_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q     <= '0;
			wr_q     <= '0;
			held_q   <= '0;
			rd_rdy_q <= 1'b0;
			wr_rdy_q <= 1'b1;
			ovf_q    <= 1'b0;
			play_q   <= 1'b0;
		end else if (v_s1) begin
			rd_q     <= rd_d;
			wr_q     <= wr_d;
			held_q   <= held_d;
			rd_rdy_q <= rd_rdy_d;
			wr_rdy_q <= wr_rdy_d;
			ovf_q    <= ovf_d;
			play_q   <= play_d;
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FullCnt)
		else $error("fill count above ring depth");

	a_rd_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_rdy_q == (held_q != '0))
		else $error("read ready out of step with fill count");

	a_wr_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_rdy_q == (held_q != FullCnt))
		else $error("write ready out of step with fill count");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !v_s1)
		else $error("word accepted while previous word in flight");

	a_write_in_stage: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (v_s1 && wr_rdy_q && !rd_rdy_d == 1'b0))
		else $error("slot write outside a receive with free slot");

endmodule
